// ===== sv/bmf_pkg.sv =====
package bmf_pkg;

   // widths fixed by the interface
   localparam int PIXEL_W      = 8;
   localparam int FRAME_SIZE_W = 5;

   // sizing
   localparam int MAX_SIDE_DEF = 16;
   localparam int MAX_RESULTS  = 17;
   localparam int MIN_SIDE     = 2;
   localparam int CNT_W        = $clog2(MAX_RESULTS - 1);
   localparam int SUM_W        = 12;
   localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = 5'd8;

   // neighborhood sizes at corner and edge
   localparam int CORNER_TAPS  = 4;
   localparam int EDGE_TAPS    = 6;

   // reciprocal multipliers, exact for sums up to 9 * 255
   localparam int RECIP_W      = 13;
   localparam int RECIP_SHIFT  = 15;
   localparam logic [RECIP_W-1:0] RECIP6 = 13'd5462;
   localparam logic [RECIP_W-1:0] RECIP9 = 13'd3641;
   localparam int CORNER_SHIFT = 2;

   // queue between gather and divide
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      DIV4 = 2'd0,
      DIV6 = 2'd1,
      DIV9 = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      div_sel_type      div_sel;
      logic             frame_end;
   } res_job_type;

endpackage

// ===== sv/bmf_front.sv =====
module bmf_front import bmf_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PIXEL_W-1:0]      req_pixel,
   input  logic                    csr_wr_en,
   input  logic [FRAME_SIZE_W-1:0] csr_wr_data,
   output logic                    job_valid,
   input  logic                    job_ready,
   output res_job_type             job
);

   localparam int SIDE_CAP  = (MAX_SIDE < MAX_RESULTS - 2) ? MAX_SIDE : MAX_RESULTS - 2;
   localparam int MEM_DEPTH = 3 * MAX_SIDE;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [FRAME_SIZE_W-1:0] frame_size_ff, frame_size_in;
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0] tr_ff, tr_in, tc_ff, tc_in, er_ff, er_in, ec_ff, ec_in;
   logic [1:0]       tslot_ff, tslot_in;
   logic [1:0]       ti_ff, ti_in, tj_ff, tj_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             tap_in_ff, tap_in_in;
   logic [PIXEL_W-1:0] rdata_ff;
   logic [PIXEL_W-1:0] mem_ff [0:MEM_DEPTH-1];

   logic [CNT_W-1:0] side, side_m1, tap_col;
   logic [CNT_W:0]   rp1, cp1;
   logic             accept, tap_inside, rd_en;
   logic [1:0]       tap_slot;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [SUM_W-1:0] sum_total;
   logic [CNT_W-1:0] cnt_total;

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      return (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

   // active side, clamped
   always_comb begin
      if (frame_size_ff < FRAME_SIZE_W'(MIN_SIDE)) begin
         side = CNT_W'(MIN_SIDE);
      end else if (frame_size_ff > FRAME_SIZE_W'(SIDE_CAP)) begin
         side = CNT_W'(SIDE_CAP);
      end else begin
         side = CNT_W'(frame_size_ff);
      end
   end
   assign side_m1 = side - CNT_W'(1);

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   // current tap position, offset by one to stay unsigned
   assign rp1 = {1'b0, tr_ff} + {{(CNT_W-1){1'b0}}, ti_ff};
   assign cp1 = {1'b0, tc_ff} + {{(CNT_W-1){1'b0}}, tj_ff};
   assign tap_inside = (rp1 != '0) && (rp1 <= {1'b0, side}) &&
                       (cp1 != '0) && (cp1 <= {1'b0, side});
   assign tap_col = CNT_W'(cp1 - (CNT_W+1)'(1));

   always_comb begin
      case (ti_ff)
         2'd0:    tap_slot = slot_prev(tslot_ff);
         2'd1:    tap_slot = tslot_ff;
         default: tap_slot = slot_next(tslot_ff);
      endcase
   end

   assign rd_addr = ADDR_W'(ADDR_W'(tap_slot * MAX_SIDE) + ADDR_W'(tap_col));
   assign wr_addr = ADDR_W'(ADDR_W'(slot_ff * MAX_SIDE) + ADDR_W'(col_ff));
   assign rd_en   = (state_ff == S_READ) && tap_inside;

   assign sum_total = sum_ff + (tap_in_ff ? SUM_W'(rdata_ff) : '0);
   assign cnt_total = cnt_ff + CNT_W'(tap_in_ff);

   assign job_valid = (state_ff == S_PUSH);
   always_comb begin
      job.sum       = sum_total;
      job.frame_end = (tr_ff == side_m1) && (tc_ff == side_m1);
      case (cnt_total)
         CNT_W'(CORNER_TAPS): job.div_sel = DIV4;
         CNT_W'(EDGE_TAPS):   job.div_sel = DIV6;
         default:             job.div_sel = DIV9;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      frame_size_in = frame_size_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      slot_in       = slot_ff;
      tr_in         = tr_ff;
      tc_in         = tc_ff;
      er_in         = er_ff;
      ec_in         = ec_ff;
      tslot_in      = tslot_ff;
      ti_in         = ti_ff;
      tj_in         = tj_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      tap_in_in     = tap_in_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((row_ff == side_m1) && (col_ff == side_m1)) begin
                  row_in  = '0;
                  col_in  = '0;
                  slot_in = '0;
               end else if (col_ff == side_m1) begin
                  col_in  = '0;
                  row_in  = row_ff + CNT_W'(1);
                  slot_in = slot_next(slot_ff);
               end else begin
                  col_in  = col_ff + CNT_W'(1);
               end
               if ((row_ff != '0) && (col_ff != '0)) begin
                  // results run in raster order from the upper-left neighbor
                  tr_in    = row_ff - CNT_W'(1);
                  tc_in    = col_ff - CNT_W'(1);
                  tslot_in = slot_prev(slot_ff);
                  if (col_ff != side_m1) begin
                     er_in = row_ff - CNT_W'(1);
                     ec_in = col_ff - CNT_W'(1);
                  end else if (row_ff != side_m1) begin
                     er_in = row_ff - CNT_W'(1);
                     ec_in = side_m1;
                  end else begin
                     er_in = side_m1;
                     ec_in = side_m1;
                  end
                  ti_in     = '0;
                  tj_in     = '0;
                  sum_in    = '0;
                  cnt_in    = '0;
                  tap_in_in = 1'b0;
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            sum_in    = sum_total;
            cnt_in    = cnt_total;
            tap_in_in = tap_inside;
            if (tj_ff == 2'd2) begin
               tj_in = '0;
               if (ti_ff == 2'd2) begin
                  state_in = S_PUSH;
               end else begin
                  ti_in = ti_ff + 2'd1;
               end
            end else begin
               tj_in = tj_ff + 2'd1;
            end
         end
         S_PUSH: begin
            if (job_ready) begin
               if ((tr_ff == er_ff) && (tc_ff == ec_ff)) begin
                  state_in = S_IDLE;
               end else begin
                  if (tc_ff == side_m1) begin
                     tr_in    = tr_ff + CNT_W'(1);
                     tc_in    = '0;
                     tslot_in = slot_next(tslot_ff);
                  end else begin
                     tc_in = tc_ff + CNT_W'(1);
                  end
                  ti_in     = '0;
                  tj_in     = '0;
                  sum_in    = '0;
                  cnt_in    = '0;
                  tap_in_in = 1'b0;
                  state_in  = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         frame_size_in = csr_wr_data;
         col_in        = '0;
         row_in        = '0;
         slot_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         frame_size_ff <= FRAME_SIZE_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         slot_ff       <= '0;
         tr_ff         <= '0;
         tc_ff         <= '0;
         er_ff         <= '0;
         ec_ff         <= '0;
         tslot_ff      <= '0;
         ti_ff         <= '0;
         tj_ff         <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         tap_in_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_size_ff <= frame_size_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         slot_ff       <= slot_in;
         tr_ff         <= tr_in;
         tc_ff         <= tc_in;
         er_ff         <= er_in;
         ec_ff         <= ec_in;
         tslot_ff      <= tslot_in;
         ti_ff         <= ti_in;
         tj_ff         <= tj_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         tap_in_ff     <= tap_in_in;
      end
   end

   // line store: three row slots, one write and one registered read port
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_ff[wr_addr] <= req_pixel;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/bmf_queue.sv =====
module bmf_queue import bmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  res_job_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output res_job_type pop_data
);

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   res_job_type entry_ff [0:QUEUE_DEPTH-1];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != (QW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QW+1)'(do_push) - (QW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/bmf_back.sv =====
module bmf_back import bmf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  res_job_type        job,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIXEL_W-1:0] rsp_smoothed,
   output logic               rsp_frame_end
);

   localparam int PROD_W = SUM_W + RECIP_W;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] smoothed_ff, smoothed_in;
   logic               frame_end_ff, frame_end_in;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  prod;
   logic               load;

   assign load      = job_valid && (!rsp_valid_ff || !rsp_stall);
   assign job_ready = load;

   // divide by 6 or 9 as multiply by reciprocal
   assign recip = (job.div_sel == DIV6) ? RECIP6 : RECIP9;
   assign prod  = PROD_W'(job.sum) * PROD_W'(recip);

   always_comb begin
      case (job.div_sel)
         DIV4:    smoothed_in = PIXEL_W'(job.sum >> CORNER_SHIFT);
         DIV6:    smoothed_in = prod[RECIP_SHIFT +: PIXEL_W];
         DIV9:    smoothed_in = prod[RECIP_SHIFT +: PIXEL_W];
         default: smoothed_in = '0;
      endcase
      frame_end_in = job.frame_end;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         smoothed_ff  <= smoothed_in;
         frame_end_ff <= frame_end_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_smoothed  = smoothed_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// ===== sv/box_mean_filter_3x3_core.sv =====
// channel  dir  handshake               payload
// req      in   req_valid / req_stall   req_pixel[7:0]
// rsp      out  rsp_valid / rsp_stall   rsp_smoothed[7:0], rsp_frame_end
// csr      in   csr_wr_en               csr_wr_data[4:0] = frame_size
//
// a pixel that completes no result leaves the front idle; for every result the
// gather sequencer steps through the nine taps over the single line store
// read port, then pushes once, and the frame's final pixel walks n+2 results
// reset is synchronous; it empties the queue and output register and sets
// frame_size to 8; the line store is not cleared and needs no clearing pass
// rsp_stall holds the output register; req_stall is high while the front walks
// a pixel's results, and stays high longer once the two-entry queue is full
module box_mean_filter_3x3_core import bmf_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PIXEL_W-1:0]      req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIXEL_W-1:0]      rsp_smoothed,
   output logic                    rsp_frame_end,
   input  logic                    csr_wr_en,
   input  logic [FRAME_SIZE_W-1:0] csr_wr_data
);

   // front to queue
   logic        fq_valid, fq_ready;
   res_job_type fq_job;
   // queue to back
   logic        qb_valid, qb_ready;
   res_job_type qb_job;

   // front: accepts pixels, writes line store, walks the results each pixel
   // completes and sums the clipped neighborhood of each one
   bmf_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel   (req_pixel),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .job_valid   (fq_valid),
      .job_ready   (fq_ready),
      .job         (fq_job)
   );

   // short queue of (sum, divisor, frame end) between the two sides
   bmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_job)
   );

   // back: divide by 4, 6 or 9 and hold the result in the output register
   bmf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (qb_valid),
      .job_ready     (qb_ready),
      .job           (qb_job),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_smoothed  (rsp_smoothed),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== sv/bmf_checker.sv =====
module bmf_checker import bmf_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [PIXEL_W-1:0] rsp_smoothed,
   input logic               rsp_frame_end
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_smoothed) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // reset empties the output side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // reset leaves the input side ready
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

   // handshake outputs are known once out of reset
   a_handshake_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({rsp_valid, req_stall}))
      else $error("handshake output unknown");

endmodule

bind box_mean_filter_3x3_core bmf_checker u_bmf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_smoothed  (rsp_smoothed),
   .rsp_frame_end (rsp_frame_end)
);
